// ===== rtl/dob_pkg.sv =====
// Shared types, constants and command codes for the detuned oscillator bank.
// No dependencies; used by every other file of the block.
`default_nettype none

package dob_pkg;

  localparam int MAX_OSC    = 64;
  localparam int OSC_IDX_W  = $clog2(MAX_OSC);
  localparam int OSC_CNT_W  = 7;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int MUL_W      = 32;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;
  localparam int SQRT_IN_W  = 48;
  localparam int SQRT_OUT_W = 24;

  // sin(pi/2 z) Taylor coefficients, Q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  // floor(0.24 cycle) at 32 phase bits
  localparam logic [29:0] EDGE_CAP   = 30'd1030792151;
  localparam logic [31:0] HALF_CYCLE = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_VOLUME,
    REG_START_DEF,
    REG_END_DEF,
    REG_COUNT,
    REG_END_INCL,
    REG_SCALE,
    REG_EDGE
  } reg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SAW,
    WAVE_SQUARE,
    WAVE_SMOOTH
  } wave_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_VOL_MUL,
    CMD_AMP_DIV,
    CMD_SQRT,
    CMD_DIFF_DIV,
    CMD_DIFF_LATCH,
    CMD_FREQ,
    CMD_INC_MUL,
    CMD_INC,
    CMD_SIMPLE,
    CMD_SIN_SQ,
    CMD_SIN_H1,
    CMD_SIN_H2,
    CMD_SIN_H3,
    CMD_SIN_H4,
    CMD_SIN_H5,
    CMD_SIN_FIN,
    CMD_SQ_W,
    CMD_SQ_WL,
    CMD_SQ_SEL,
    CMD_SQ_T,
    CMD_SQ_T2,
    CMD_SQ_FIN,
    CMD_ACC_MUL,
    CMD_ACC,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic  zero;
    wave_t mode;
    logic  div_busy;
    logic  sqrt_busy;
    logic  sq_edge;
    logic  last;
    logic  out_free;
  } status_t;

  typedef struct packed {
    logic signed [19:0] start_freq;
    logic               use_start_freq;
    logic signed [19:0] end_freq;
    logic               use_end_freq;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               clipped;
  } sample_t;

  function automatic logic [OSC_CNT_W-1:0] eff_count(input logic [OSC_CNT_W-1:0] c);
    logic [OSC_CNT_W-1:0] r;
    if (c == '0) r = OSC_CNT_W'(1);
    else if (c > OSC_CNT_W'(MAX_OSC)) r = OSC_CNT_W'(MAX_OSC);
    else r = c;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/detuned_oscillator_bank.sv =====
// Channel   Dir  Handshake         Word
// tick      in   tick_valid/stall  dob_pkg::tick_t (start/end freq overrides)
// sample    out  sample_valid/stall dob_pkg::sample_t (Q1.15 sum, clip flag)
// cfg       in   cfg_valid/ready   cfg_index, cfg_data (register write)
//
// One tick word at a time. Setup per word runs two divides and a square root
// with their launch states, then each oscillator takes the sawtooth/square,
// sine or smoothed-square path, where a smoothed-square edge runs another
// divide and a plateau does not, then a finish step ends the word.
// Zero frequency or volume goes straight to the finish step.
// Synchronous reset; the phase store reads zero after reset via valid bits.
// A finished sample waits in the output register while the next tick runs.
`default_nettype none

module detuned_oscillator_bank (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            tick_valid,
  output logic                                 tick_stall,
  input  wire dob_pkg::tick_t                  tick,
  output logic                                 sample_valid,
  input  wire logic                            sample_stall,
  output dob_pkg::sample_t                     sample,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dob_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dob_pkg::cmd_t    cmd;
  dob_pkg::status_t status;

  assign cfg_ready = 1'b1;

  dob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dob_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .tick        (tick),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall)
  );

endmodule

`default_nettype wire

// ===== rtl/dob_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on dob_pkg for operand widths.
`default_nettype none

module dob_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [dob_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [dob_pkg::DIV_DEN_W-1:0]  den,
  output logic                                busy,
  output logic [dob_pkg::DIV_NUM_W-1:0]       quot,
  output logic [dob_pkg::DIV_DEN_W-1:0]       rem
);

  localparam int CNT_W = $clog2(dob_pkg::DIV_NUM_W);

  logic [dob_pkg::DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]              cnt;
  logic [dob_pkg::DIV_DEN_W:0]   rem_sh;
  logic [dob_pkg::DIV_DEN_W:0]   rem_dif;
  logic                          ge;

  assign rem_sh  = {rem, quot[dob_pkg::DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_dif = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(dob_pkg::DIV_NUM_W - 1)) busy <= 1'b0;
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quot <= {quot[dob_pkg::DIV_NUM_W-2:0], ge};
      rem  <= ge ? rem_dif[dob_pkg::DIV_DEN_W-1:0] : rem_sh[dob_pkg::DIV_DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dob_sqrt.sv =====
// Integer square root, one result bit per cycle (digit by digit).
// Depends on dob_pkg for operand widths.
`default_nettype none

module dob_sqrt (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [dob_pkg::SQRT_IN_W-1:0]   val,
  output logic                                 busy,
  output logic [dob_pkg::SQRT_OUT_W-1:0]       root
);

  localparam int CNT_W = $clog2(dob_pkg::SQRT_OUT_W);
  localparam int REM_W = dob_pkg::SQRT_OUT_W + 2;

  logic [dob_pkg::SQRT_IN_W-1:0] rad;
  logic [REM_W-1:0]              rem;
  logic [CNT_W-1:0]              cnt;
  logic [REM_W+1:0]              rem_t;
  logic [REM_W+1:0]              trial;
  logic                          ge;

  assign rem_t = {rem, rad[dob_pkg::SQRT_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(dob_pkg::SQRT_OUT_W - 1)) busy <= 1'b0;
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= val;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[dob_pkg::SQRT_IN_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root <= {root[dob_pkg::SQRT_OUT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dob_datapath.sv =====
// Datapath: config registers, phase memory, shared multiplier, divider and
// square root units, accumulator and output register. Depends on dob_pkg,
// dob_div and dob_sqrt; driven by commands from dob_ctrl.
`default_nettype none

module dob_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dob_pkg::cmd_t                     cmd,
  output dob_pkg::status_t                       status,
  input  wire dob_pkg::tick_t                    tick,
  input  wire logic                              cfg_valid,
  input  wire logic [dob_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dob_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dob_pkg::sample_t                       sample,
  output logic                                   sample_valid,
  input  wire logic                              sample_stall
);

  localparam int MUL_WW = dob_pkg::MUL_W;

  // configuration
  dob_pkg::wave_t  mode;
  logic [15:0]     volume;
  logic [18:0]     start_def;
  logic [18:0]     end_def;
  logic [6:0]      osc_count;
  logic            end_incl;
  logic [27:0]     scale;
  logic [10:0]     edge_len;

  // per-sample state
  logic signed [19:0] fs, fe;
  logic               zero;
  logic [6:0]         n;
  logic [23:0]        amp;
  logic signed [22:0] q_step, q;
  logic [7:0]         r_step, r;
  logic [dob_pkg::OSC_IDX_W-1:0] k;
  logic signed [47:0] sum;

  // per-oscillator state
  logic signed [20:0] f;
  logic [31:0]        p;
  logic [35:0]        mag;
  logic [31:0]        inc;
  logic [30:0]        s;
  logic [29:0]        w;
  logic signed [16:0] v;
  logic               sq_edge;
  logic               sq_fall;
  logic [16:0]        t;
  logic [63:0]        prod;

  // phase memory and valid bits
  logic [31:0] phase_mem [dob_pkg::MAX_OSC];
  logic [31:0] mem_q;
  logic        rd_valid;
  logic [dob_pkg::MAX_OSC-1:0] pvalid;

  // shared units
  logic                            div_start, sqrt_start;
  logic [dob_pkg::DIV_NUM_W-1:0]   div_num, div_quot;
  logic [dob_pkg::DIV_DEN_W-1:0]   div_den, div_rem;
  logic                            div_busy, sqrt_busy;
  logic [dob_pkg::SQRT_OUT_W-1:0]  sqrt_root;

  // combinational helpers
  logic signed [19:0] fs_sel, fe_sel;
  logic [6:0]         d;
  logic [7:0]         two_d;
  logic signed [21:0] two_diff;
  logic [21:0]        diff_abs;
  logic               fneg;
  logic [19:0]        fmag;
  logic [30:0]        z;
  logic [30:0]        prod_q30;
  logic [10:0]        e_eff;
  logic [31:0]        dabs;
  logic [30:0]        x_rise, x_fall;
  logic               rise, high, fall;
  logic [16:0]        t_c;
  logic [16:0]        vabs;
  logic [16:0]        sin_r;
  logic [16:0]        sin_cap;
  logic [16:0]        sq_s;
  logic signed [22:0] qa;
  logic               rnz;
  logic [8:0]         r_sum;
  logic signed [47:0] rnd;
  logic signed [24:0] res;
  logic [MUL_WW-1:0]  mul_a, mul_b;
  logic               mul_en;

  assign fs_sel   = tick.use_start_freq ? tick.start_freq : $signed({1'b0, start_def});
  assign fe_sel   = tick.use_end_freq ? tick.end_freq : $signed({1'b0, end_def});
  assign d        = end_incl ? n - 7'd1 : n;
  assign two_d    = {d, 1'b0};
  assign two_diff = ($signed({{2{fe[19]}}, fe}) - $signed({{2{fs[19]}}, fs})) <<< 1;
  assign diff_abs = two_diff[21] ? 22'(-two_diff) : two_diff;
  assign fneg     = f[20];
  assign fmag     = fneg ? 20'(-f) : f[19:0];
  assign z        = p[30] ? 31'h4000_0000 - {1'b0, p[29:22], 22'b0}
                          : {1'b0, p[29:22], 22'b0};
  assign prod_q30 = prod[60:30];
  assign e_eff    = (edge_len < 11'd2) ? 11'd2 : edge_len;
  assign dabs     = p[31] ? 32'd0 - p : p;
  assign rise     = dabs < {2'b00, w};
  assign x_rise   = p[31] ? 31'({1'b0, w} - dabs[30:0]) : 31'(p[30:0] + {1'b0, w});
  assign high     = p < (dob_pkg::HALF_CYCLE - {2'b00, w});
  assign fall     = p < (dob_pkg::HALF_CYCLE + {2'b00, w});
  assign x_fall   = 31'(p - (dob_pkg::HALF_CYCLE - {2'b00, w}));
  assign t_c      = (div_quot > 48'd65536) ? 17'd65536 : div_quot[16:0];
  assign vabs     = v[16] ? 17'(-v) : v;
  assign sin_r    = 17'(({1'b0, prod_q30} + 32'd16384) >> 15);
  assign sin_cap  = (sin_r > 17'd32768) ? 17'd32768 : sin_r;
  assign sq_s     = prod[32:16];
  assign qa       = $signed(div_quot[22:0]);
  assign rnz      = div_rem != '0;
  assign r_sum    = {1'b0, r} + {1'b0, r_step};
  assign rnd      = sum + 48'sd4194304;
  assign res      = rnd[47:23];

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd)
      dob_pkg::CMD_VOL_MUL: begin
        mul_a = MUL_WW'(volume);
        mul_b = MUL_WW'(volume);
      end
      dob_pkg::CMD_INC_MUL: begin
        mul_a = MUL_WW'(fmag);
        mul_b = MUL_WW'(scale);
      end
      dob_pkg::CMD_SIN_SQ: begin
        mul_a = MUL_WW'(z);
        mul_b = MUL_WW'(z);
      end
      dob_pkg::CMD_SIN_H1: begin
        mul_a = MUL_WW'(dob_pkg::SIN_C9);
        mul_b = MUL_WW'(prod_q30);
      end
      dob_pkg::CMD_SIN_H2: begin
        mul_a = MUL_WW'(dob_pkg::SIN_C7 - prod_q30);
        mul_b = MUL_WW'(s);
      end
      dob_pkg::CMD_SIN_H3: begin
        mul_a = MUL_WW'(dob_pkg::SIN_C5 - prod_q30);
        mul_b = MUL_WW'(s);
      end
      dob_pkg::CMD_SIN_H4: begin
        mul_a = MUL_WW'(dob_pkg::SIN_C3 - prod_q30);
        mul_b = MUL_WW'(s);
      end
      dob_pkg::CMD_SIN_H5: begin
        mul_a = MUL_WW'(dob_pkg::SIN_C1 - prod_q30);
        mul_b = MUL_WW'(z);
      end
      dob_pkg::CMD_SQ_W: begin
        mul_a = MUL_WW'(mag[29:0]);
        mul_b = MUL_WW'(e_eff);
      end
      dob_pkg::CMD_SQ_T: begin
        mul_a = MUL_WW'(t_c);
        mul_b = MUL_WW'(t_c);
      end
      dob_pkg::CMD_SQ_T2: begin
        mul_a = MUL_WW'(prod[32:16]);
        mul_b = MUL_WW'(18'd196608 - {t, 1'b0});
      end
      dob_pkg::CMD_ACC_MUL: begin
        mul_a = MUL_WW'(vabs);
        mul_b = MUL_WW'(amp);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  // divider and square root launch
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd)
      dob_pkg::CMD_AMP_DIV: begin
        div_start = 1'b1;
        div_num   = {prod[31:0], 16'b0};
        div_den   = dob_pkg::DIV_DEN_W'(n);
      end
      dob_pkg::CMD_DIFF_DIV: begin
        div_start = 1'b1;
        div_num   = dob_pkg::DIV_NUM_W'(diff_abs);
        div_den   = (n == 7'd1) ? dob_pkg::DIV_DEN_W'(1) : dob_pkg::DIV_DEN_W'(two_d);
      end
      dob_pkg::CMD_SQ_SEL: begin
        div_start = rise || (!high && fall);
        div_num   = rise ? {1'b0, x_rise, 16'b0} : {1'b0, x_fall, 16'b0};
        div_den   = {1'b0, w, 1'b0};
      end
      default: ;
    endcase
  end

  assign sqrt_start = (cmd == dob_pkg::CMD_SQRT);

  dob_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (div_quot),
    .rem  (div_rem)
  );

  dob_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .val  (div_quot),
    .busy (sqrt_busy),
    .root (sqrt_root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= dob_pkg::WAVE_SINE;
      volume    <= 16'd16384;
      start_def <= 19'd7040;
      end_def   <= 19'd7040;
      osc_count <= 7'd1;
      end_incl  <= 1'b1;
      scale     <= 28'd22906492;
      edge_len  <= 11'd48;
    end else if (cfg_valid) begin
      unique case (dob_pkg::reg_idx_t'(cfg_index))
        dob_pkg::REG_MODE:      mode      <= dob_pkg::wave_t'(cfg_data[1:0]);
        dob_pkg::REG_VOLUME:    volume    <= cfg_data[15:0];
        dob_pkg::REG_START_DEF: start_def <= cfg_data[18:0];
        dob_pkg::REG_END_DEF:   end_def   <= cfg_data[18:0];
        dob_pkg::REG_COUNT:     osc_count <= cfg_data[6:0];
        dob_pkg::REG_END_INCL:  end_incl  <= cfg_data[0];
        dob_pkg::REG_SCALE:     scale     <= cfg_data[27:0];
        dob_pkg::REG_EDGE:      edge_len  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // phase valid bits: a count write drops phases at or above the new count
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
    end else if (cfg_valid && cfg_index == dob_pkg::REG_COUNT) begin
      for (int i = 0; i < dob_pkg::MAX_OSC; i++) begin
        if (dob_pkg::OSC_CNT_W'(i) >= dob_pkg::eff_count(cfg_data[6:0])) pvalid[i] <= 1'b0;
      end
    end else if (cmd == dob_pkg::CMD_ACC) begin
      pvalid[k] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == dob_pkg::CMD_ACC) phase_mem[k] <= p + inc;
    if (cmd == dob_pkg::CMD_FREQ) begin
      mem_q    <= phase_mem[k];
      rd_valid <= pvalid[k];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd)
      dob_pkg::CMD_LOAD: begin
        fs   <= fs_sel;
        fe   <= fe_sel;
        zero <= (fs_sel == '0) || (fe_sel == '0) || (volume == '0);
        n    <= dob_pkg::eff_count(osc_count);
        sum  <= '0;
      end
      dob_pkg::CMD_DIFF_DIV: amp <= sqrt_root;
      dob_pkg::CMD_DIFF_LATCH: begin
        // floor division of the per-oscillator step, done once per sample
        if (n == 7'd1) begin
          q_step <= '0;
          r_step <= '0;
        end else if (two_diff[21]) begin
          q_step <= 23'sd0 - qa - $signed({22'b0, rnz});
          r_step <= rnz ? two_d - div_rem[7:0] : 8'd0;
        end else begin
          q_step <= qa;
          r_step <= div_rem[7:0];
        end
        q <= '0;
        r <= {1'b0, d};
        k <= '0;
      end
      dob_pkg::CMD_FREQ: f <= 21'($signed({{3{fs[19]}}, fs}) + q);
      dob_pkg::CMD_INC_MUL: p <= rd_valid ? mem_q : 32'd0;
      dob_pkg::CMD_INC: begin
        mag <= prod[47:12];
        inc <= fneg ? 32'd0 - prod[43:12] : prod[43:12];
      end
      dob_pkg::CMD_SIMPLE: begin
        if (mode == dob_pkg::WAVE_SAW) v <= $signed({1'b0, p[31:16]}) - 17'sd32768;
        else v <= p[31] ? -17'sd32768 : 17'sd32768;
      end
      dob_pkg::CMD_SIN_H1: s <= prod_q30;
      dob_pkg::CMD_SIN_FIN: v <= p[31] ? 17'(-sin_cap) : sin_cap;
      dob_pkg::CMD_SQ_WL: begin
        if (mag > 36'(dob_pkg::EDGE_CAP) || prod > 64'(dob_pkg::EDGE_CAP)) w <= dob_pkg::EDGE_CAP;
        else w <= prod[29:0];
      end
      dob_pkg::CMD_SQ_SEL: begin
        sq_fall <= !rise;
        if (rise) begin
          sq_edge <= 1'b1;
        end else if (high) begin
          sq_edge <= 1'b0;
          v       <= 17'sd32768;
        end else if (fall) begin
          sq_edge <= 1'b1;
        end else begin
          sq_edge <= 1'b0;
          v       <= -17'sd32768;
        end
      end
      dob_pkg::CMD_SQ_T: t <= t_c;
      dob_pkg::CMD_SQ_FIN: begin
        if (sq_fall) v <= 17'sd32768 - $signed(sq_s);
        else v <= $signed(sq_s) - 17'sd32768;
      end
      dob_pkg::CMD_ACC: begin
        if (v[16]) sum <= sum - $signed({8'b0, prod[39:0]});
        else sum <= sum + $signed({8'b0, prod[39:0]});
        k <= k + dob_pkg::OSC_IDX_W'(1);
        if (r_sum >= {1'b0, two_d}) begin
          r <= 8'(r_sum - {1'b0, two_d});
          q <= q + q_step + 23'sd1;
        end else begin
          r <= r_sum[7:0];
          q <= q + q_step;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (cmd == dob_pkg::CMD_FINISH) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == dob_pkg::CMD_FINISH) begin
      if (res > 25'sd32767) begin
        sample.sample_out <= 16'sh7fff;
        sample.clipped    <= 1'b1;
      end else if (res < -25'sd32768) begin
        sample.sample_out <= 16'sh8000;
        sample.clipped    <= 1'b1;
      end else begin
        sample.sample_out <= res[15:0];
        sample.clipped    <= 1'b0;
      end
    end
  end

  assign status.zero      = zero;
  assign status.mode      = mode;
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.sq_edge   = sq_edge;
  assign status.last      = ({1'b0, k} == n - 7'd1);
  assign status.out_free  = !sample_valid || !sample_stall;

endmodule

`default_nettype wire

// ===== rtl/dob_ctrl.sv =====
// Controller: sequences the datapath through setup, the oscillator loop and
// the output step. Depends on dob_pkg for command and status types.
`default_nettype none

module dob_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick_valid,
  output logic                   tick_stall,
  input  wire dob_pkg::status_t  status,
  output dob_pkg::cmd_t          cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_AMP_DIV,
    S_AMP_WAIT,
    S_SQRT_WAIT,
    S_DIFF_WAIT,
    S_FREQ,
    S_INC_MUL,
    S_INC,
    S_SIMPLE,
    S_SIN_SQ,
    S_SIN_H1,
    S_SIN_H2,
    S_SIN_H3,
    S_SIN_H4,
    S_SIN_H5,
    S_SIN_FIN,
    S_SQ_W,
    S_SQ_WL,
    S_SQ_SEL,
    S_SQ_WAIT,
    S_SQ_T2,
    S_SQ_FIN,
    S_ACC_MUL,
    S_ACC,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = dob_pkg::CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (tick_valid && !rst) begin
          cmd        = dob_pkg::CMD_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.zero) begin
          state_next = S_FINISH;
        end else begin
          cmd        = dob_pkg::CMD_VOL_MUL;
          state_next = S_AMP_DIV;
        end
      end
      S_AMP_DIV: begin
        cmd        = dob_pkg::CMD_AMP_DIV;
        state_next = S_AMP_WAIT;
      end
      S_AMP_WAIT: begin
        if (!status.div_busy) begin
          cmd        = dob_pkg::CMD_SQRT;
          state_next = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (!status.sqrt_busy) begin
          cmd        = dob_pkg::CMD_DIFF_DIV;
          state_next = S_DIFF_WAIT;
        end
      end
      S_DIFF_WAIT: begin
        if (!status.div_busy) begin
          cmd        = dob_pkg::CMD_DIFF_LATCH;
          state_next = S_FREQ;
        end
      end
      S_FREQ: begin
        cmd        = dob_pkg::CMD_FREQ;
        state_next = S_INC_MUL;
      end
      S_INC_MUL: begin
        cmd        = dob_pkg::CMD_INC_MUL;
        state_next = S_INC;
      end
      S_INC: begin
        cmd = dob_pkg::CMD_INC;
        unique case (status.mode)
          dob_pkg::WAVE_SINE:   state_next = S_SIN_SQ;
          dob_pkg::WAVE_SMOOTH: state_next = S_SQ_W;
          default:              state_next = S_SIMPLE;
        endcase
      end
      S_SIMPLE: begin
        cmd        = dob_pkg::CMD_SIMPLE;
        state_next = S_ACC_MUL;
      end
      S_SIN_SQ: begin
        cmd        = dob_pkg::CMD_SIN_SQ;
        state_next = S_SIN_H1;
      end
      S_SIN_H1: begin
        cmd        = dob_pkg::CMD_SIN_H1;
        state_next = S_SIN_H2;
      end
      S_SIN_H2: begin
        cmd        = dob_pkg::CMD_SIN_H2;
        state_next = S_SIN_H3;
      end
      S_SIN_H3: begin
        cmd        = dob_pkg::CMD_SIN_H3;
        state_next = S_SIN_H4;
      end
      S_SIN_H4: begin
        cmd        = dob_pkg::CMD_SIN_H4;
        state_next = S_SIN_H5;
      end
      S_SIN_H5: begin
        cmd        = dob_pkg::CMD_SIN_H5;
        state_next = S_SIN_FIN;
      end
      S_SIN_FIN: begin
        cmd        = dob_pkg::CMD_SIN_FIN;
        state_next = S_ACC_MUL;
      end
      S_SQ_W: begin
        cmd        = dob_pkg::CMD_SQ_W;
        state_next = S_SQ_WL;
      end
      S_SQ_WL: begin
        cmd        = dob_pkg::CMD_SQ_WL;
        state_next = S_SQ_SEL;
      end
      S_SQ_SEL: begin
        cmd        = dob_pkg::CMD_SQ_SEL;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        // plateaus skip the edge division
        if (!status.sq_edge) begin
          state_next = S_ACC_MUL;
        end else if (!status.div_busy) begin
          cmd        = dob_pkg::CMD_SQ_T;
          state_next = S_SQ_T2;
        end
      end
      S_SQ_T2: begin
        cmd        = dob_pkg::CMD_SQ_T2;
        state_next = S_SQ_FIN;
      end
      S_SQ_FIN: begin
        cmd        = dob_pkg::CMD_SQ_FIN;
        state_next = S_ACC_MUL;
      end
      S_ACC_MUL: begin
        cmd        = dob_pkg::CMD_ACC_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd        = dob_pkg::CMD_ACC;
        state_next = status.last ? S_FINISH : S_FREQ;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd        = dob_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign tick_stall = (state != S_IDLE) || rst;

endmodule

`default_nettype wire

// ===== rtl/dob_checker.sv =====
// Port-level checks for detuned_oscillator_bank, bound to the top level.
// Depends on dob_pkg for the word types.
`default_nettype none

module dob_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             tick_valid,
  input wire logic             tick_stall,
  input wire logic             sample_valid,
  input wire logic             sample_stall,
  input wire dob_pkg::sample_t sample
);

  // one tick at a time
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> tick_stall)
    else $error("tick accepted while previous tick still busy");

  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_stall) |=> (sample_valid && $stable(sample)))
    else $error("stalled sample word changed");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample.clipped) |->
      (sample.sample_out == 16'sh7fff || sample.sample_out == 16'sh8000))
    else $error("clip flag without full-scale value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sample_valid)
    else $error("sample valid after reset");

endmodule

bind detuned_oscillator_bank dob_checker u_dob_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick_valid),
  .tick_stall  (tick_stall),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .sample      (sample)
);

`default_nettype wire
